FILE: design/assert_macros.svh
// Assertion macros used by the top level of the desk height controller.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: design/dhpc_pkg.sv
// Types and constants for the desk height preset controller.
// No dependencies.
`default_nettype none

package dhpc_pkg;

   localparam logic [7:0]  POS_FRAME_ID       = 8'h92;
   localparam logic [31:0] SHORT_PRESS_MS     = 32'd300;
   localparam logic [31:0] QUIET_MS           = 32'd500;
   localparam logic [9:0]  ANALOG_PRESS_LEVEL = 10'd50;
   localparam logic [15:0] STORE_LOW          = 16'd150;
   localparam logic [15:0] STORE_HIGH         = 16'd6400;
   localparam logic [15:0] PRESET_RESET       = 16'd3500;
   localparam logic [7:0]  THRESHOLD_RESET    = 8'd120;
   localparam logic [7:0]  CLICKS_MOVE        = 8'd2;
   localparam logic [7:0]  CLICKS_STORE       = 8'd3;

   typedef enum logic [1:0] {
      BTN_NONE = 2'd0,
      BTN_UP   = 2'd1,
      BTN_DOWN = 2'd2
   } btn_type;

   localparam logic [1:0] DIR_STOP = 2'd0;
   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;

   localparam logic [1:0] WR_NONE = 2'd0;
   localparam logic [1:0] WR_ONE  = 2'd1;
   localparam logic [1:0] WR_TWO  = 2'd2;

   typedef struct packed {
      logic [15:0] position;
      logic [15:0] target;
      logic        seeded;
      logic [15:0] preset_one;
      logic [15:0] preset_two;
      logic        up_held;
      logic        down_held;
      btn_type     pending;
      btn_type     last;
      logic [31:0] press_time;
      logic [31:0] release_time;
      logic [7:0]  click_count;
      logic        auto_flag;
   } state_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        frame_valid;
      logic [7:0]  frame_id;
      logic [7:0]  frame_byte1;
      logic [7:0]  frame_byte2;
      logic        up_button_low;
      logic        down_button_low;
      logic [9:0]  up_level;
      logic [9:0]  down_level;
   } req_type;

   typedef struct packed {
      logic [1:0]  drive_direction;
      logic [15:0] position_now;
      logic [15:0] target_now;
      logic        auto_moving;
      logic [1:0]  preset_written;
      logic        preset_rejected;
   } rsp_type;

endpackage

`default_nettype wire

FILE: design/dhpc_pass.sv
// One controller pass: next state and result word from state and request word.
// Depends on dhpc_pkg.
`default_nettype none

module dhpc_pass (
   input  dhpc_pkg::state_type state_i,
   input  dhpc_pkg::req_type   req_i,
   input  logic [7:0]          threshold,
   output dhpc_pkg::state_type state_o,
   output dhpc_pkg::rsp_type   rsp_o
);
   import dhpc_pkg::*;

   logic [15:0] frame_pos;
   logic        pos_update;
   logic [15:0] pos1;
   logic [15:0] tgt1;
   logic        quiet;
   state_type   s;
   logic [1:0]  dir;
   logic [1:0]  written;
   logic        rejected;

   assign frame_pos  = {req_i.frame_byte2, req_i.frame_byte1};
   assign pos_update = req_i.frame_valid && (req_i.frame_id == POS_FRAME_ID)
                       && (frame_pos != state_i.position);
   assign pos1 = pos_update ? frame_pos : state_i.position;
   assign tgt1 = (pos_update && !state_i.seeded) ? frame_pos : state_i.target;

   always_comb begin
      dir = DIR_STOP;
      if (pos1 > tgt1) begin
         if ((pos1 - tgt1) > {8'd0, threshold}) begin
            dir = DIR_DOWN;
         end
      end else begin
         if ((tgt1 - pos1) > {8'd0, threshold}) begin
            dir = DIR_UP;
         end
      end
   end

   always_comb begin
      s          = state_i;
      s.position = pos1;
      s.target   = tgt1;
      s.seeded   = state_i.seeded | pos_update;
      written    = WR_NONE;
      rejected   = 1'b0;

      // up first, then down: down wins pending and last
      if (req_i.up_button_low) begin
         s.pending = BTN_UP;
         if (!s.up_held) begin
            s.press_time = req_i.now_ms;
            s.up_held    = 1'b1;
            s.last       = BTN_UP;
         end
      end else if (s.up_held) begin
         s.pending      = BTN_UP;
         s.release_time = req_i.now_ms;
         s.up_held      = 1'b0;
      end
      if (req_i.down_button_low) begin
         s.pending = BTN_DOWN;
         if (!s.down_held) begin
            s.press_time = req_i.now_ms;
            s.down_held  = 1'b1;
            s.last       = BTN_DOWN;
         end
      end else if (s.down_held) begin
         s.pending      = BTN_DOWN;
         s.release_time = req_i.now_ms;
         s.down_held    = 1'b0;
      end

      if (s.auto_flag) begin
         if ((req_i.up_level < ANALOG_PRESS_LEVEL) ||
             (req_i.down_level < ANALOG_PRESS_LEVEL)) begin
            s.target    = pos1;
            s.auto_flag = 1'b0;
         end
      end else begin
         s.target = pos1;
      end

      if ((s.pending != BTN_NONE) &&
          ((s.release_time - s.press_time) < SHORT_PRESS_MS)) begin
         s.click_count = s.click_count + 8'd1;
         s.press_time  = 32'd0;
         s.pending     = BTN_NONE;
      end

      if (quiet) begin
         if (s.click_count == CLICKS_MOVE) begin
            s.auto_flag = 1'b1;
            if (s.last == BTN_UP) begin
               s.target = s.preset_one;
            end else if (s.last == BTN_DOWN) begin
               s.target = s.preset_two;
            end
         end else if (s.click_count == CLICKS_STORE) begin
            if ((s.last == BTN_UP) || (s.last == BTN_DOWN)) begin
               if ((pos1 > STORE_LOW) && (pos1 < STORE_HIGH)) begin
                  if (s.last == BTN_UP) begin
                     s.preset_one = pos1;
                     written      = WR_ONE;
                  end else begin
                     s.preset_two = pos1;
                     written      = WR_TWO;
                  end
               end else begin
                  rejected = 1'b1;
               end
            end
         end
         s.click_count = 8'd0;
         s.last        = BTN_NONE;
      end
   end

   // quiet test uses the release time after button sampling
   always_comb begin
      logic [31:0] rel;
      rel = state_i.release_time;
      if (!req_i.up_button_low && state_i.up_held) begin
         rel = req_i.now_ms;
      end
      if (!req_i.down_button_low && state_i.down_held) begin
         rel = req_i.now_ms;
      end
      quiet = (req_i.now_ms - rel) > QUIET_MS;
   end

   assign state_o = s;

   always_comb begin
      rsp_o.drive_direction = dir;
      rsp_o.position_now    = s.position;
      rsp_o.target_now      = s.target;
      rsp_o.auto_moving     = s.auto_flag;
      rsp_o.preset_written  = written;
      rsp_o.preset_rejected = rejected;
   end

endmodule

`default_nettype wire

FILE: design/desk_height_preset_controller.sv
// Desk height preset controller: top level with request register, state and result register.
// Depends on dhpc_pkg, dhpc_pass and assert_macros.svh.
`default_nettype none

// One request word is one controller pass. A word is accepted every clock
// while req_ready is high: the request lands
// in an input register, one pass of compare and select logic updates the
// state, and the result is held in an output register until taken. With the
// output stalled both registers fill and req_ready drops. Writes to the
// threshold register take effect for later passes.
module desk_height_preset_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_now_ms,
   input  logic        req_frame_valid,
   input  logic [7:0]  req_frame_id,
   input  logic [7:0]  req_frame_byte1,
   input  logic [7:0]  req_frame_byte2,
   input  logic        req_up_button_low,
   input  logic        req_down_button_low,
   input  logic [9:0]  req_up_level,
   input  logic [9:0]  req_down_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_drive_direction,
   output logic [15:0] rsp_position_now,
   output logic [15:0] rsp_target_now,
   output logic        rsp_auto_moving,
   output logic [1:0]  rsp_preset_written,
   output logic        rsp_preset_rejected,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);
   import dhpc_pkg::*;

   `include "assert_macros.svh"

   req_type   req_ff;
   req_type   req_in;
   logic      req_full_ff;
   logic      req_full_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   state_type state_ff;
   state_type state_in;
   state_type state_next;
   logic [7:0] threshold_ff;
   logic [7:0] threshold_in;
   logic      advance;
   logic      accept;

   assign advance   = req_full_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_full_ff || advance;
   assign accept    = req_valid && req_ready;

   dhpc_pass u_pass (
      .state_i   (state_ff),
      .req_i     (req_ff),
      .threshold (threshold_ff),
      .state_o   (state_next),
      .rsp_o     (rsp_in)
   );

   always_comb begin
      req_in.now_ms          = req_now_ms;
      req_in.frame_valid     = req_frame_valid;
      req_in.frame_id        = req_frame_id;
      req_in.frame_byte1     = req_frame_byte1;
      req_in.frame_byte2     = req_frame_byte2;
      req_in.up_button_low   = req_up_button_low;
      req_in.down_button_low = req_down_button_low;
      req_in.up_level        = req_up_level;
      req_in.down_level      = req_down_level;
   end

   assign req_full_in  = accept || (req_full_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   assign state_in     = advance ? state_next : state_ff;
   assign threshold_in = csr_write_enable ? csr_write_data : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_full_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         threshold_ff          <= THRESHOLD_RESET;
         state_ff.position     <= 16'd0;
         state_ff.target       <= 16'd0;
         state_ff.seeded       <= 1'b0;
         state_ff.preset_one   <= PRESET_RESET;
         state_ff.preset_two   <= PRESET_RESET;
         state_ff.up_held      <= 1'b0;
         state_ff.down_held    <= 1'b0;
         state_ff.pending      <= BTN_NONE;
         state_ff.last         <= BTN_NONE;
         state_ff.press_time   <= 32'd0;
         state_ff.release_time <= 32'd0;
         state_ff.click_count  <= 8'd0;
         state_ff.auto_flag    <= 1'b0;
      end else begin
         req_full_ff  <= req_full_in;
         rsp_valid_ff <= rsp_valid_in;
         threshold_ff <= threshold_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive_direction = rsp_ff.drive_direction;
   assign rsp_position_now    = rsp_ff.position_now;
   assign rsp_target_now      = rsp_ff.target_now;
   assign rsp_auto_moving     = rsp_ff.auto_moving;
   assign rsp_preset_written  = rsp_ff.preset_written;
   assign rsp_preset_rejected = rsp_ff.preset_rejected;

   `ASSERT_IMPLIES(a_stall_full, clock, reset, !req_ready, req_full_ff && rsp_valid_ff)
   `ASSERT_NEXT(a_state_hold, clock, reset, !advance, $stable(state_ff))
   `ASSERT_IMPLIES(a_store_excl, clock, reset, rsp_valid && (rsp_preset_written != WR_NONE),
      !rsp_preset_rejected)

endmodule

`default_nettype wire
